@@ rtl/core/rmq_pkg.sv @@
package rmq_pkg;

  // Width of one matrix element and one quaternion component
  localparam int unsigned ElemW = 16;
  // Sum or difference of two elements
  localparam int unsigned DiffW = ElemW + 1;
  // Number of divided components per item
  localparam int unsigned Lanes = 3;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } pivot_case_e;

endpackage

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           xaxis_*_i, yaxis_*_i, zaxis_*_i
// result    out        done_o (one-cycle strobe) quat_x/y/z/w_o, pivot_case_o
//
// A transaction is taken at every edge with start_i high; busy_o stays low.
// The pipe holds RW root stages, FRAC_BITS + 4 divider stages, and the prep,
// pivot and output registers.
// Rate is one transaction per cycle; the root and divider units are fully
// pipelined, one result bit per stage.
// Reset clears only the valid bits; data registers are free-running.
// The receiver cannot stall, so nothing in the pipe ever holds.
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [rmq_pkg::ElemW-1:0]  xaxis_x_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  xaxis_y_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  xaxis_z_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  yaxis_x_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  yaxis_y_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  yaxis_z_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  zaxis_x_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  zaxis_y_i,
  input  logic signed [rmq_pkg::ElemW-1:0]  zaxis_z_i,
  output logic                              done_o,
  output logic signed [rmq_pkg::ElemW-1:0]  quat_x_o,
  output logic signed [rmq_pkg::ElemW-1:0]  quat_y_o,
  output logic signed [rmq_pkg::ElemW-1:0]  quat_z_o,
  output logic signed [rmq_pkg::ElemW-1:0]  quat_w_o,
  output logic        [1:0]                 pivot_case_o
);
  import rmq_pkg::*;

  // Radicand is below 2^(max(F,17)+1); scaled by 2^F before the root
  localparam int unsigned SW     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned RW     = (SW - 1 + FRAC_BITS + 1) / 2;
  localparam int unsigned QW     = FRAC_BITS + 2;
  localparam int unsigned CW     = (RW > FRAC_BITS + 1) ? RW : FRAC_BITS + 1;
  localparam int unsigned OW     = ((QW > ElemW) ? QW : ElemW) + 1;
  localparam int unsigned SQ_SW  = 2 + Lanes * DiffW;
  localparam int unsigned DV_SW  = 2 + RW;
  localparam int unsigned LAT    = RW + QW + 5;

  // Prep: trace, pivot choice, radicand and the three off-diagonal terms
  logic                    pr_vld;
  pivot_case_e             pr_case;
  logic        [2*RW-1:0]  pr_rad;
  logic signed [DiffW-1:0] pr_d [Lanes];

  rmq_prep #(
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .RW        (RW)
  ) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .xx_i   (xaxis_x_i),
    .xy_i   (xaxis_y_i),
    .xz_i   (xaxis_z_i),
    .yx_i   (yaxis_x_i),
    .yy_i   (yaxis_y_i),
    .yz_i   (yaxis_z_i),
    .zx_i   (zaxis_x_i),
    .zy_i   (zaxis_y_i),
    .zz_i   (zaxis_z_i),
    .vld_o  (pr_vld),
    .case_o (pr_case),
    .rad_o  (pr_rad),
    .d_o    (pr_d)
  );

  // Root: carry case and terms alongside
  logic [SQ_SW-1:0] sq_side_in, sq_side_out;
  logic             sq_vld;
  logic [RW-1:0]    sq_root;

  assign sq_side_in = {pr_case, pr_d[0], pr_d[1], pr_d[2]};

  rmq_sqrt_pipe #(
    .RW     (RW),
    .SIDE_W (SQ_SW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pr_vld),
    .rad_i  (pr_rad),
    .side_i (sq_side_in),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side_out)
  );

  // Pivot register: p = round(root / 2), ties up
  logic                    pv_vld_q;
  logic        [RW-1:0]    pv_p_q;
  logic        [1:0]       pv_case_q;
  logic signed [DiffW-1:0] pv_d_q [Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_vld_q <= 1'b0;
    end else begin
      pv_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_p_q    <= RW'(((RW+1)'(sq_root) + (RW+1)'(1)) >> 1);
    pv_case_q <= sq_side_out[SQ_SW-1 -: 2];
    pv_d_q[0] <= sq_side_out[3*DiffW-1 -: DiffW];
    pv_d_q[1] <= sq_side_out[2*DiffW-1 -: DiffW];
    pv_d_q[2] <= sq_side_out[DiffW-1:0];
  end

  // Three dividers in lockstep
  logic             dv_vld;
  logic [QW-1:0]    dv_quot [Lanes];
  logic             dv_ovf  [Lanes];
  logic             dv_neg  [Lanes];
  logic [DV_SW-1:0] dv_side;

  rmq_div_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .PW        (RW),
    .SIDE_W    (DV_SW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pv_vld_q),
    .d_i    (pv_d_q),
    .p_i    (pv_p_q),
    .side_i ({pv_case_q, pv_p_q}),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .ovf_o  (dv_ovf),
    .neg_o  (dv_neg),
    .side_o (dv_side)
  );

  // Saturate, apply sign, route lanes back to components
  pivot_case_e         fin_case;
  logic [CW-1:0]       fin_p;
  logic signed [OW-1:0] lane_v [Lanes];
  logic signed [OW-1:0] piv_v;
  logic [ElemW-1:0]    lane_o [Lanes];
  logic [ElemW-1:0]    piv_o;
  logic [ElemW-1:0]    qx_d, qy_d, qz_d, qw_d;

  always_comb begin
    fin_case = pivot_case_e'(dv_side[DV_SW-1 -: 2]);
    fin_p    = CW'(dv_side[RW-1:0]);
    for (int k = 0; k < Lanes; k++) begin
      logic [QW-1:0] mag;
      mag = (dv_ovf[k] || dv_quot[k] > (QW'(1) << FRAC_BITS)) ?
            (QW'(1) << FRAC_BITS) : dv_quot[k];
      lane_v[k] = dv_neg[k] ? -OW'(mag) : OW'(mag);
      lane_o[k] = lane_v[k][ElemW-1:0];
    end
    piv_v = (fin_p > (CW'(1) << FRAC_BITS)) ? (OW'(1) << FRAC_BITS) : OW'(fin_p);
    piv_o = piv_v[ElemW-1:0];
    unique case (fin_case)
      CASE_TRACE: begin
        qx_d = lane_o[0]; qy_d = lane_o[1]; qz_d = lane_o[2]; qw_d = piv_o;
      end
      CASE_X: begin
        qx_d = piv_o; qy_d = lane_o[0]; qz_d = lane_o[1]; qw_d = lane_o[2];
      end
      CASE_Y: begin
        qx_d = lane_o[0]; qy_d = piv_o; qz_d = lane_o[1]; qw_d = lane_o[2];
      end
      default: begin
        qx_d = lane_o[0]; qy_d = lane_o[1]; qz_d = piv_o; qw_d = lane_o[2];
      end
    endcase
  end

  logic             done_q;
  logic [ElemW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic [1:0]       case_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    qz_q   <= qz_d;
    qw_q   <= qw_d;
    case_q <= fin_case;
  end

  assign busy_o       = 1'b0;
  assign done_o       = done_q;
  assign quat_x_o     = qx_q;
  assign quat_y_o     = qy_q;
  assign quat_z_o     = qz_q;
  assign quat_w_o     = qw_q;
  assign pivot_case_o = case_q;

  // Every accepted transaction comes out after a fixed latency
  a_latency_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o)
    else $error("result missing at fixed latency");

  // No result without an accepted transaction behind it
  a_latency_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##LAT !done_o)
    else $error("result without transaction");

  // Pivot component is never negative (checked for FRAC_BITS up to 14)
  a_pivot_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (FRAC_BITS <= 14) |->
      ((pivot_case_o == CASE_TRACE && !quat_w_o[ElemW-1]) ||
       (pivot_case_o == CASE_X && !quat_x_o[ElemW-1]) ||
       (pivot_case_o == CASE_Y && !quat_y_o[ElemW-1]) ||
       (pivot_case_o == CASE_Z && !quat_z_o[ElemW-1])))
    else $error("negative pivot component");

endmodule

@@ rtl/core/rmq_prep.sv @@
module rmq_prep #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned SW        = 19,
  parameter int unsigned RW        = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    vld_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        xx_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        xy_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        xz_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        yx_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        yy_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        yz_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        zx_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        zy_i,
  input  logic signed [rmq_pkg::ElemW-1:0]        zz_i,
  output logic                                    vld_o,
  output rmq_pkg::pivot_case_e                    case_o,
  output logic        [2*RW-1:0]                  rad_o,
  output logic signed [rmq_pkg::DiffW-1:0]        d_o [rmq_pkg::Lanes]
);
  import rmq_pkg::*;

  logic signed [SW-1:0] xx, yy, zz, tr, one, s, s_pos;
  logic signed [DiffW-1:0] yz_m_zy, zx_m_xz, xy_m_yx, yx_p_xy, zx_p_xz, zy_p_yz;
  pivot_case_e case_d;
  logic signed [DiffW-1:0] d_d [Lanes];

  logic                    vld_q;
  pivot_case_e             case_q;
  logic        [2*RW-1:0]  rad_q;
  logic signed [DiffW-1:0] d_q [Lanes];

  always_comb begin
    xx  = SW'(xx_i);
    yy  = SW'(yy_i);
    zz  = SW'(zz_i);
    one = SW'(1) <<< FRAC_BITS;
    tr  = xx + yy + zz;
    yz_m_zy = DiffW'(yz_i) - DiffW'(zy_i);
    zx_m_xz = DiffW'(zx_i) - DiffW'(xz_i);
    xy_m_yx = DiffW'(xy_i) - DiffW'(yx_i);
    yx_p_xy = DiffW'(yx_i) + DiffW'(xy_i);
    zx_p_xz = DiffW'(zx_i) + DiffW'(xz_i);
    zy_p_yz = DiffW'(zy_i) + DiffW'(yz_i);
    if (tr > 0) begin
      case_d = CASE_TRACE;
      s      = one + tr;
      d_d[0] = yz_m_zy;
      d_d[1] = zx_m_xz;
      d_d[2] = xy_m_yx;
    end else if (xx > yy && xx > zz) begin
      case_d = CASE_X;
      s      = one + xx - yy - zz;
      d_d[0] = yx_p_xy;
      d_d[1] = zx_p_xz;
      d_d[2] = yz_m_zy;
    end else if (yy > zz) begin
      case_d = CASE_Y;
      s      = one + yy - xx - zz;
      d_d[0] = yx_p_xy;
      d_d[1] = zy_p_yz;
      d_d[2] = zx_m_xz;
    end else begin
      case_d = CASE_Z;
      s      = one + zz - xx - yy;
      d_d[0] = zx_p_xz;
      d_d[1] = zy_p_yz;
      d_d[2] = xy_m_yx;
    end
    s_pos = (s > 0) ? s : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    case_q <= case_d;
    rad_q  <= (2*RW)'(s_pos[SW-2:0]) << FRAC_BITS;
    d_q    <= d_d;
  end

  assign vld_o  = vld_q;
  assign case_o = case_q;
  assign rad_o  = rad_q;
  assign d_o    = d_q;

endmodule

@@ rtl/core/rmq_sqrt_pipe.sv @@
module rmq_sqrt_pipe #(
  parameter int unsigned RW     = 16,
  parameter int unsigned SIDE_W = 53
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [RW];
  logic [2*RW-1:0]   rad_q  [RW];
  logic [RW+1:0]     rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SIDE_W-1:0] side_q [RW];

  // One root bit per stage, two radicand bits consumed per stage
  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic              vld_in;
    logic [2*RW-1:0]   rad_in;
    logic [RW+1:0]     rem_in;
    logic [RW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW+1:0]     rem_sh, trial, rem_d;
    logic [RW-1:0]     root_d;
    logic              ge;

    if (j == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      rem_sh = {rem_in[RW-1:0], rad_in[2*(RW-1-j)+1 -: 2]};
      trial  = {root_in, 2'b01};
      ge     = rem_sh >= trial;
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_in[RW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[j]  <= rad_in;
      rem_q[j]  <= rem_d;
      root_q[j] <= root_d;
      side_q[j] <= side_in;
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

@@ rtl/core/rmq_div_pipe.sv @@
module rmq_div_pipe #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned PW        = 16,
  parameter int unsigned SIDE_W    = 18
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 vld_i,
  input  logic signed [rmq_pkg::DiffW-1:0]     d_i    [rmq_pkg::Lanes],
  input  logic        [PW-1:0]                 p_i,
  input  logic        [SIDE_W-1:0]             side_i,
  output logic                                 vld_o,
  output logic        [FRAC_BITS+1:0]          quot_o [rmq_pkg::Lanes],
  output logic                                 ovf_o  [rmq_pkg::Lanes],
  output logic                                 neg_o  [rmq_pkg::Lanes],
  output logic        [SIDE_W-1:0]             side_o
);
  import rmq_pkg::*;

  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned NUMW = DiffW + FRAC_BITS + 1;
  localparam int unsigned DENW = PW + 2;
  localparam int unsigned DW   = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;
  localparam int unsigned NS   = QW + 1;

  // Input stage: numerator with rounding term, divisor 4p
  logic              in_vld_q;
  logic [DW-1:0]     in_num_q [Lanes];
  logic              in_neg_q [Lanes];
  logic [DENW-1:0]   in_den_q;
  logic [SIDE_W-1:0] in_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Lanes; k++) begin
      logic [DiffW-1:0] mag;
      mag = d_i[k][DiffW-1] ? DiffW'(-d_i[k]) : DiffW'(d_i[k]);
      in_num_q[k] <= (DW'(mag) << FRAC_BITS) + (DW'(p_i) << 1);
      in_neg_q[k] <= d_i[k][DiffW-1];
    end
    in_den_q  <= {p_i, 2'b00};
    in_side_q <= side_i;
  end

  logic              vld_q  [NS];
  logic [DW-1:0]     rem_q  [NS][Lanes];
  logic [QW-1:0]     quo_q  [NS][Lanes];
  logic              ovf_q  [NS][Lanes];
  logic              neg_q  [NS][Lanes];
  logic [DENW-1:0]   den_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  // First stage only detects a quotient beyond QW bits; then one bit per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned B = QW - s;
    logic              vld_in;
    logic [DW-1:0]     rem_in [Lanes];
    logic [QW-1:0]     quo_in [Lanes];
    logic              ovf_in [Lanes];
    logic              neg_in [Lanes];
    logic [DENW-1:0]   den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW-1:0]     den_sh;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld_q;
      assign rem_in  = in_num_q;
      assign quo_in  = '{default: '0};
      assign ovf_in  = '{default: 1'b0};
      assign neg_in  = in_neg_q;
      assign den_in  = in_den_q;
      assign side_in = in_side_q;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign ovf_in  = ovf_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign den_sh = DW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < Lanes; k++) begin
        if (s == 0) begin
          rem_q[s][k] <= rem_in[k];
          quo_q[s][k] <= quo_in[k];
          ovf_q[s][k] <= rem_in[k] >= den_sh;
        end else if (rem_in[k] >= den_sh) begin
          rem_q[s][k] <= rem_in[k] - den_sh;
          quo_q[s][k] <= quo_in[k] | (QW'(1) << B);
          ovf_q[s][k] <= ovf_in[k];
        end else begin
          rem_q[s][k] <= rem_in[k];
          quo_q[s][k] <= quo_in[k];
          ovf_q[s][k] <= ovf_in[k];
        end
        neg_q[s][k] <= neg_in[k];
      end
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign quot_o = quo_q[NS-1];
  assign ovf_o  = ovf_q[NS-1];
  assign neg_o  = neg_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

@@ dv/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int unsigned Frac = 14;
  localparam longint OneRaw = longint'(1) << Frac;
  // Pipeline depth of the block at FRAC_BITS 14
  localparam int unsigned Latency = 37;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    pivot_case_e        pc;
  } quat_t;

  typedef logic signed [15:0] elem_t;
  typedef elem_t mat_t [9];

  // Integer square root of an unsigned 64-bit value, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint half_root(longint s);
    longint unsigned us;
    us = (s > 0) ? longint'(s) : 0;
    return longint'((int_sqrt(us << Frac) + 1) >> 1);
  endfunction

  // round(d * one / (4p)), ties away from zero
  function automatic longint quarter_div(longint d, longint p);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << Frac) + longint'(p) * 2) / (longint'(p) * 4);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > OneRaw) v = OneRaw;
    if (v < -OneRaw) v = -OneRaw;
    return v[15:0];
  endfunction

  function automatic quat_t shepperd_quat(mat_t m);
    longint xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, p, qx, qy, qz, qw;
    quat_t r;
    xx = m[0]; xy = m[1]; xz = m[2];
    yx = m[3]; yy = m[4]; yz = m[5];
    zx = m[6]; zy = m[7]; zz = m[8];
    tr = xx + yy + zz;
    if (tr > 0) begin
      p = half_root(OneRaw + tr);
      qw = p;
      qx = quarter_div(yz - zy, p);
      qy = quarter_div(zx - xz, p);
      qz = quarter_div(xy - yx, p);
      r.pc = CASE_TRACE;
    end else if (xx > yy && xx > zz) begin
      p = half_root(OneRaw + xx - yy - zz);
      qx = p;
      qy = quarter_div(yx + xy, p);
      qz = quarter_div(zx + xz, p);
      qw = quarter_div(yz - zy, p);
      r.pc = CASE_X;
    end else if (yy > zz) begin
      p = half_root(OneRaw + yy - xx - zz);
      qy = p;
      qx = quarter_div(yx + xy, p);
      qz = quarter_div(zy + yz, p);
      qw = quarter_div(zx - xz, p);
      r.pc = CASE_Y;
    end else begin
      p = half_root(OneRaw + zz - xx - yy);
      qz = p;
      qx = quarter_div(zx + xz, p);
      qy = quarter_div(zy + yz, p);
      qw = quarter_div(xy - yx, p);
      r.pc = CASE_Z;
    end
    r.qx = sat16(qx);
    r.qy = sat16(qy);
    r.qz = sat16(qz);
    r.qw = sat16(qw);
    return r;
  endfunction

  // Holds pending quaternions in issue order and compares each result strobe
  class quat_scoreboard;
    quat_t pending[$];
    int    errors;

    function void note_matrix(mat_t m);
      pending.push_back(shepperd_quat(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      if (got.qx !== exp_q.qx) begin
        $error("quat_x exp %0d got %0d", exp_q.qx, got.qx); errors++;
      end
      if (got.qy !== exp_q.qy) begin
        $error("quat_y exp %0d got %0d", exp_q.qy, got.qy); errors++;
      end
      if (got.qz !== exp_q.qz) begin
        $error("quat_z exp %0d got %0d", exp_q.qz, got.qz); errors++;
      end
      if (got.qw !== exp_q.qw) begin
        $error("quat_w exp %0d got %0d", exp_q.qw, got.qw); errors++;
      end
      if (got.pc !== exp_q.pc) begin
        $error("pivot_case exp %0d got %0d", exp_q.pc, got.pc); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  elem_t xaxis_x_i = '0, xaxis_y_i = '0, xaxis_z_i = '0;
  elem_t yaxis_x_i = '0, yaxis_y_i = '0, yaxis_z_i = '0;
  elem_t zaxis_x_i = '0, zaxis_y_i = '0, zaxis_z_i = '0;
  elem_t quat_x_o, quat_y_o, quat_z_o, quat_w_o;
  logic [1:0] pivot_case_o;

  quat_scoreboard sb = new();
  int idle_pct;

  always #1 clk_i = ~clk_i;

  rotation_matrix_to_quaternion uut (.*);

  // Sample results at the edge that ends the strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      sb.check_quat({quat_x_o, quat_y_o, quat_z_o, quat_w_o, pivot_case_e'(pivot_case_o)});
  end

  // Drive one matrix and hold it until the block takes the transaction
  task automatic send_matrix(mat_t m);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    xaxis_x_i <= m[0]; xaxis_y_i <= m[1]; xaxis_z_i <= m[2];
    yaxis_x_i <= m[3]; yaxis_y_i <= m[4]; yaxis_z_i <= m[5];
    zaxis_x_i <= m[6]; zaxis_y_i <= m[7]; zaxis_z_i <= m[8];
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    sb.note_matrix(m);
  endtask

  // Random element: mostly in range, sometimes any 16-bit pattern
  function automatic elem_t rand_elem();
    case ($urandom_range(9))
      0: return elem_t'($urandom);
      1: return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
      2: return elem_t'($urandom_range(64)) - 16'sd32;
      default: return elem_t'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  // Proper rotation from a random quaternion, so the pivot math is exercised cleanly
  function automatic mat_t rand_rotation();
    real a, b, c, d, n;
    mat_t m;
    a = $urandom_range(2000) - 1000.0; b = $urandom_range(2000) - 1000.0;
    c = $urandom_range(2000) - 1000.0; d = $urandom_range(2000) - 1000.0;
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n < 1.0) begin
      a = 1.0; n = 1.0;
    end
    a /= n; b /= n; c /= n; d /= n;
    // columns: x axis, y axis, z axis (w = a)
    m[0] = elem_t'($rtoi(16384.0 * (1 - 2*(c*c + d*d))));
    m[1] = elem_t'($rtoi(16384.0 * (2*(b*c + a*d))));
    m[2] = elem_t'($rtoi(16384.0 * (2*(b*d - a*c))));
    m[3] = elem_t'($rtoi(16384.0 * (2*(b*c - a*d))));
    m[4] = elem_t'($rtoi(16384.0 * (1 - 2*(b*b + d*d))));
    m[5] = elem_t'($rtoi(16384.0 * (2*(c*d + a*b))));
    m[6] = elem_t'($rtoi(16384.0 * (2*(b*d + a*c))));
    m[7] = elem_t'($rtoi(16384.0 * (2*(c*d - a*b))));
    m[8] = elem_t'($rtoi(16384.0 * (1 - 2*(b*b + c*c))));
    return m;
  endfunction

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    mat_t m;
    idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: identity, half turns, pivot ties, extremes, garbage patterns
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};        send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};      send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};      send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};      send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
    m = '{-5, 0, 0, 0, -5, 0, 0, 0, 10};                 send_matrix(m);
    m = '{-100, 0, 0, 0, -100, 0, 0, 0, -100};           send_matrix(m);
    m = '{-50, 0, 0, 0, -10, 0, 0, 0, -10};              send_matrix(m);
    m = '{-10, 0, 0, 0, -10, 0, 0, 0, -50};              send_matrix(m);
    m = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384};       send_matrix(m);
    m = '{-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384};
    send_matrix(m);
    m = '{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384};
    send_matrix(m);
    m = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_matrix(m);
    m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_matrix(m);
    m = '{-32768, 32767, 32767, -32768, -32768, 32767, -32768, -32768, -32768};
    send_matrix(m);
    m = '{1, 0, 0, 0, 0, 0, 0, 0, 0};                    send_matrix(m);
    m = '{-16384, 16384, -16384, 16384, -16384, 16384, -16384, 16384, -16384};
    send_matrix(m);
    // pause the sender until the pipe has emptied
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 18 : (ph == 1) ? 75 : 0;
      for (int i = 0; i < 550; i++) begin
        if ($urandom_range(9) < 7) begin
          m = rand_rotation();
        end else begin
          foreach (m[k]) m[k] = rand_elem();
        end
        send_matrix(m);
      end
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
